// File: hdl/cdmd_pkg.sv
package cdmd_pkg;

  // default line buffer depth
  localparam int MAX_WIDTH_DEF = 1024;

  // register field widths
  localparam int COLOR_MODE_W   = 2;
  localparam int THRESHOLD_W    = 8;
  localparam int FRAME_WIDTH_W  = 11;
  localparam int FRAME_HEIGHT_W = 12;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  // pixel and result fields
  localparam int CHAN_W = 8;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 11;

  // stream word widths
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;

  // tuser bit positions on the input side
  localparam int TUSER_FRAME_START = 0;
  localparam int TUSER_FLUSH       = 1;

  // color modes, any other code behaves as off
  localparam logic [COLOR_MODE_W-1:0] MODE_RED  = 2'd0;
  localparam logic [COLOR_MODE_W-1:0] MODE_BLUE = 2'd1;
  localparam logic [COLOR_MODE_W-1:0] MODE_OFF  = 2'd2;

  // reset values
  localparam logic [COLOR_MODE_W-1:0]   COLOR_MODE_RST   = MODE_RED;
  localparam logic [THRESHOLD_W-1:0]    THRESHOLD_RST    = 8'd100;
  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COLOR_MODE   = 2'd0,
    REG_THRESHOLD    = 2'd1,
    REG_FRAME_WIDTH  = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } cfg_reg_e;

  // register contents as seen by the datapath
  typedef struct packed {
    logic [COLOR_MODE_W-1:0]   color_mode;
    logic [THRESHOLD_W-1:0]    diff_threshold;
    logic [FRAME_WIDTH_W-1:0]  frame_width;
    logic [FRAME_HEIGHT_W-1:0] frame_height;
  } cfg_t;

endpackage

// File: hdl/cdmd_cfg_regs.sv
module cdmd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cdmd_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [cdmd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output cdmd_pkg::cfg_t                cfg_o
);
  import cdmd_pkg::*;

  cfg_t cfg_q;

  // writes are taken in any cycle
  assign cfg_ready_o = 1'b1;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_mode     <= COLOR_MODE_RST;
      cfg_q.diff_threshold <= THRESHOLD_RST;
      cfg_q.frame_width    <= FRAME_WIDTH_RST;
      cfg_q.frame_height   <= FRAME_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_COLOR_MODE:   cfg_q.color_mode     <= cfg_data_i[COLOR_MODE_W-1:0];
        REG_THRESHOLD:    cfg_q.diff_threshold <= cfg_data_i[THRESHOLD_W-1:0];
        REG_FRAME_WIDTH:  cfg_q.frame_width    <= cfg_data_i[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: cfg_q.frame_height   <= cfg_data_i[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/cdmd_line_mem.sv
module cdmd_line_mem #(
  parameter int MAX_WIDTH = cdmd_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr0_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr1_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr_i,
  input  logic [1:0]                   wr_data_i,  // bit 0 newer row, bit 1 older row
  output logic [1:0]                   rd_data0_o, // both rows at the first address
  output logic                         rd_data1_o, // newer row at the second address
  output logic                         clr_busy_o
);
  import cdmd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic [1:0]    mem [MAX_WIDTH];
  logic [1:0]    rd0_q;
  logic          rd1_q;
  logic          clr_busy_q;
  logic [CW-1:0] clr_addr_q;

  // clearing sweep after reset, one entry per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + CW'(1);
      if (clr_addr_q == CW'(MAX_WIDTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // storage, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= 2'b00;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd0_q <= mem[rd_addr0_i];
      rd1_q <= mem[rd_addr1_i][0];
    end
  end

  assign rd_data0_o = rd0_q;
  assign rd_data1_o = rd1_q;
  assign clr_busy_o = clr_busy_q;

endmodule

// File: hdl/cdmd_pipe.sv
module cdmd_pipe #(
  parameter int MAX_WIDTH = cdmd_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cdmd_pkg::cfg_t                  cfg_i,
  input  logic                            clr_busy_i,
  // pixel words
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [cdmd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [cdmd_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  // result words
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cdmd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,
  // line memory
  output logic                            rd_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    rd_addr0_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    rd_addr1_o,
  output logic                            wr_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]    wr_addr_o,
  output logic [1:0]                      wr_data_o,
  input  logic [1:0]                      rd_data0_i,
  input  logic                            rd_data1_i
);
  import cdmd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > FRAME_WIDTH_W) ? CW + 1 : FRAME_WIDTH_W;
  localparam int RW = FRAME_HEIGHT_W + 1;
  localparam int XW = CW + COL_W;

  // position of the next pixel
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;

  // stage one: item waiting for its line memory data
  logic          s1_valid_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic          s1_mask_q;
  logic          s1_flush_q;
  logic          s1_right_ok_q;
  logic          s1_last_q;
  logic          fwd0_q;
  logic          fwd1_q;
  logic [1:0]    fwd_word_q;
  logic          prev_centre_q;

  // result register
  logic                   out_valid_q;
  logic                   out_mask_q;
  logic [COL_W-1:0]       out_col_q;
  logic [ROW_W-1:0]       out_row_q;
  logic                   out_last_q;

  // stage zero signals
  logic [EW-1:0]             width_raw;
  logic [EW-1:0]             width_eff;
  logic [RW-1:0]             height_eff;
  logic                      flush;
  logic                      frame_start;
  logic [CHAN_W-1:0]         blue;
  logic [CHAN_W-1:0]         red;
  logic                      restart;
  logic [CW-1:0]             c0;
  logic [RW-1:0]             r0;
  logic [CW:0]               c0_inc;
  logic                      last_col;
  logic                      keep;
  logic                      accept;
  logic                      go;
  logic signed [CHAN_W:0]    diff;
  logic signed [CHAN_W:0]    thr;
  logic                      pix_mask;

  // stage one signals
  logic       s1_adv;
  logic       s1_emit;
  logic       s1_write;
  logic [1:0] word0;
  logic       above;
  logic       centre;
  logic       right_bit;
  logic       left_bit;
  logic       dil_bit;
  logic [RW-1:0] row_m1;
  logic [XW-1:0] col_ext;

  // field unpacking
  assign blue        = s_axis_tdata[CHAN_W-1:0];
  assign red         = s_axis_tdata[2*CHAN_W-1:CHAN_W];
  assign frame_start = s_axis_tuser[TUSER_FRAME_START];
  assign flush       = s_axis_tuser[TUSER_FLUSH];

  // effective geometry
  always_comb begin
    width_raw = EW'(cfg_i.frame_width);
    if (width_raw == '0) begin
      width_eff = EW'(1);
    end else if (width_raw > EW'(MAX_WIDTH)) begin
      width_eff = EW'(MAX_WIDTH);
    end else begin
      width_eff = width_raw;
    end
    if (cfg_i.frame_height == '0) begin
      height_eff = RW'(1);
    end else begin
      height_eff = RW'(cfg_i.frame_height);
    end
  end

  // position of this word and whether it counts
  assign restart  = !flush && frame_start;
  assign c0       = restart ? '0 : col_q;
  assign r0       = restart ? '0 : row_q;
  assign c0_inc   = {1'b0, c0} + (CW + 1)'(1);
  assign last_col = EW'(c0_inc) >= width_eff;
  assign keep     = flush ? (r0 == height_eff) : (r0 < height_eff);

  // threshold on the channel difference
  always_comb begin
    thr = $signed({1'b0, cfg_i.diff_threshold});
    if (cfg_i.color_mode == MODE_BLUE) begin
      diff = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      diff = $signed({1'b0, red}) - $signed({1'b0, blue});
    end
    if (flush || cfg_i.color_mode == MODE_OFF) begin
      pix_mask = 1'b0;
    end else if (cfg_i.color_mode == MODE_RED || cfg_i.color_mode == MODE_BLUE) begin
      pix_mask = diff > thr;
    end else begin
      pix_mask = 1'b0;
    end
  end

  // handshakes
  assign s1_emit       = s1_row_q != '0;
  assign s1_adv        = s1_valid_q && (!s1_emit || !out_valid_q || m_axis_tready);
  assign s1_write      = s1_adv && !s1_flush_q;
  assign s_axis_tready = !clr_busy_i && (!s1_valid_q || s1_adv);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign go            = accept && keep;

  // line memory reads issued on acceptance
  assign rd_en_o    = go;
  assign rd_addr0_o = c0;
  assign rd_addr1_o = c0_inc[CW-1:0];

  // position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (go) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= r0 + RW'(1);
      end else begin
        col_q <= c0_inc[CW-1:0];
        row_q <= r0;
      end
    end
  end

  // stage one control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      prev_centre_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= keep;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        prev_centre_q <= centre;
      end
    end
  end

  // stage one payload, with bypass of the write that lands on the same edge
  always_ff @(posedge clk_i) begin
    if (go) begin
      s1_col_q      <= c0;
      s1_row_q      <= r0;
      s1_mask_q     <= pix_mask;
      s1_flush_q    <= flush;
      s1_right_ok_q <= !last_col;
      s1_last_q     <= (r0 == height_eff) && last_col;
      fwd0_q        <= s1_write && (s1_col_q == c0);
      fwd1_q        <= s1_write && (s1_col_q == c0_inc[CW-1:0]);
      fwd_word_q    <= wr_data_o;
    end
  end

  // cross dilation
  assign word0     = fwd0_q ? fwd_word_q : rd_data0_i;
  assign centre    = word0[0];
  assign above     = (s1_row_q >= RW'(2)) && word0[1];
  assign right_bit = s1_right_ok_q && (fwd1_q ? fwd_word_q[0] : rd_data1_i);
  assign left_bit  = (s1_col_q != '0) && prev_centre_q;
  assign dil_bit   = above | left_bit | centre | right_bit | s1_mask_q;

  // line memory update: newer row shifts into older
  assign wr_en_o   = s1_write;
  assign wr_addr_o = s1_col_q;
  assign wr_data_o = {centre, s1_mask_q};

  assign row_m1  = s1_row_q - RW'(1);
  assign col_ext = XW'(s1_col_q);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit) begin
      out_mask_q <= dil_bit;
      out_col_q  <= col_ext[COL_W-1:0];
      out_row_q  <= row_m1[ROW_W-1:0];
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_row_q, out_col_q, out_mask_q});
  assign m_axis_tlast  = out_last_q;

endmodule

// File: hdl/color_difference_mask_dilate_top.sv
// channel     dir  handshake                 contents
// s_axis      in   s_axis_tvalid/tready      colour pixels or flush words
// m_axis      out  m_axis_tvalid/tready      dilated mask bits with position
// cfg         in   cfg_valid_i/cfg_ready_o   register index and write data
//
// one pixel word per cycle sustained while m_axis keeps up and no clear sweep runs;
// a result word passes the stage-one and result registers after its source word is
// taken, and each row appears one row later than its input
// after reset the line memory is swept clean, with tready low; a stalled m_axis
// fills the result and stage-one registers, then holds s_axis_tready low
// configuration writes are taken in every cycle
module color_difference_mask_dilate_top #(
  parameter int MAX_WIDTH = cdmd_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [cdmd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // blue, red
  input  logic [cdmd_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // frame_start, flush
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [cdmd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // mask, col, row, zero pad
  output logic                              m_axis_tlast,  // frame_last
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cdmd_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [cdmd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import cdmd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  cfg_t          cfg;
  logic          clr_busy;
  logic          rd_en;
  logic [CW-1:0] rd_addr0;
  logic [CW-1:0] rd_addr1;
  logic          wr_en;
  logic [CW-1:0] wr_addr;
  logic [1:0]    wr_data;
  logic [1:0]    rd_data0;
  logic          rd_data1;

  // configuration registers
  cdmd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // two mask rows, one word per column
  cdmd_line_mem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr0_i (rd_addr0),
    .rd_addr1_i (rd_addr1),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rd_data0_o (rd_data0),
    .rd_data1_o (rd_data1),
    .clr_busy_o (clr_busy)
  );

  // threshold, dilation and result register
  cdmd_pipe #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .clr_busy_i    (clr_busy),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .rd_en_o       (rd_en),
    .rd_addr0_o    (rd_addr0),
    .rd_addr1_o    (rd_addr1),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .rd_data0_i    (rd_data0),
    .rd_data1_i    (rd_data1)
  );

endmodule

// File: sim/color_difference_mask_dilate_top_tb.sv
module color_difference_mask_dilate_top_tb;
  import cdmd_pkg::*;

  localparam int MAX_W = MAX_WIDTH_DEF;
  localparam int STALL_CYCLES = 400;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] red;
    logic              frame_start;
    logic              flush;
  } pixel_word_t;

  typedef struct packed {
    logic             mask;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } dil_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // blue, red
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;  // frame_start, flush
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // mask, col, row, zero pad
  logic                   m_axis_tlast;        // frame_last
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i = REG_COLOR_MODE;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;

  // pending pixel words and expected dilated results
  pixel_word_t pixel_q[$];
  dil_result_t dil_expect_q[$];
  int          words_queued = 0;
  int          words_sent   = 0;
  int          err_cnt      = 0;

  // traffic shaping
  bit calm      = 1'b0;
  bit stall_req = 1'b0;
  bit stall_seen = 1'b0;
  int hold_left = 0;

  // register copies
  logic [COLOR_MODE_W-1:0]   mode_q   = COLOR_MODE_RST;
  logic [THRESHOLD_W-1:0]    thresh_q = THRESHOLD_RST;
  logic [FRAME_WIDTH_W-1:0]  width_q  = FRAME_WIDTH_RST;
  logic [FRAME_HEIGHT_W-1:0] height_q = FRAME_HEIGHT_RST;

  // line buffers, window and input position
  bit          newer_row [MAX_W];
  bit          older_row [MAX_W];
  logic [2:0]  win_q   = '0;
  int unsigned col_cnt = 0;
  int unsigned row_cnt = 0;

  color_difference_mask_dilate_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  task automatic flag_mismatch(input string msg);
    err_cnt++;
    $display("ERROR: %s", msg);
  endtask

  function automatic int unsigned eff_width();
    int unsigned w;
    w = 32'(width_q);
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    return (height_q == 0) ? 1 : 32'(height_q);
  endfunction

  // signed channel difference against the threshold
  function automatic bit pixel_hit(input logic [CHAN_W-1:0] blue, input logic [CHAN_W-1:0] red);
    int b_v, r_v, t_v;
    b_v = 32'(blue);
    r_v = 32'(red);
    t_v = 32'(thresh_q);
    case (mode_q)
      MODE_RED:  return (r_v - b_v) > t_v;
      MODE_BLUE: return (b_v - r_v) > t_v;
      default:   return 1'b0;
    endcase
  endfunction

  // cross dilation over two stored rows, one row of latency
  task automatic predict_dilated(input pixel_word_t px);
    int unsigned w, h, c, r, row_m1;
    bit          m, above, centre, right_n, left_n;
    dil_result_t res;
    w = eff_width();
    h = eff_height();
    if (!px.flush && px.frame_start) begin
      col_cnt = 0;
      row_cnt = 0;
      win_q   = '0;
    end
    c = col_cnt;
    r = row_cnt;
    if (c >= MAX_W) c = MAX_W - 1;
    if (px.flush) begin
      if (r != h) return;
      m = 1'b0;
    end else begin
      if (r >= h) return;
      m = pixel_hit(px.blue, px.red);
    end
    above   = (r >= 2) ? older_row[c] : 1'b0;
    centre  = newer_row[c];
    right_n = (c + 1 < w && c + 1 < MAX_W) ? newer_row[c + 1] : 1'b0;
    left_n  = (c >= 1) ? win_q[0] : 1'b0;
    win_q   = {win_q[1:0], centre};
    if (!px.flush) begin
      older_row[c] = centre;
      newer_row[c] = m;
    end
    if (r >= 1) begin
      row_m1   = r - 1;
      res.mask = above | left_n | centre | right_n | m;
      res.col  = c[COL_W-1:0];
      res.row  = row_m1[ROW_W-1:0];
      res.last = (r == h) && (c + 1 >= w);
      dil_expect_q.push_back(res);
    end
    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  // pixel word driver, predicts each word as it is taken
  always @(posedge clk_i) begin : drive_pixels
    pixel_word_t nxt;
    pixel_word_t taken;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        taken.blue        = s_axis_tdata[7:0];
        taken.red         = s_axis_tdata[15:8];
        taken.frame_start = s_axis_tuser[TUSER_FRAME_START];
        taken.flush       = s_axis_tuser[TUSER_FLUSH];
        predict_dilated(taken);
        words_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pixel_q.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
          nxt = pixel_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {nxt.red, nxt.blue};
          s_axis_tuser  <= {nxt.flush, nxt.frame_start};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result ready, with a long hold-off when requested
  always @(posedge clk_i) begin
    if (stall_req && !stall_seen) hold_left = STALL_CYCLES;
    stall_seen = stall_req;
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 8);
    end
  end

  // result checker
  always @(posedge clk_i) begin : check_results
    dil_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (dil_expect_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result word row %0d col %0d",
                                m_axis_tdata[21:11], m_axis_tdata[10:1]));
      end else begin
        want = dil_expect_q.pop_front();
        if (m_axis_tdata[0] !== want.mask)
          flag_mismatch($sformatf("mask %b, want %b at row %0d col %0d",
                                  m_axis_tdata[0], want.mask, want.row, want.col));
        if (m_axis_tdata[10:1] !== want.col)
          flag_mismatch($sformatf("col %0d, want %0d", m_axis_tdata[10:1], want.col));
        if (m_axis_tdata[21:11] !== want.row)
          flag_mismatch($sformatf("row %0d, want %0d", m_axis_tdata[21:11], want.row));
        if (m_axis_tlast !== want.last)
          flag_mismatch($sformatf("frame_last %b, want %b at row %0d col %0d",
                                  m_axis_tlast, want.last, want.row, want.col));
      end
    end
  end

  task automatic push_word(input logic [CHAN_W-1:0] blue, input logic [CHAN_W-1:0] red,
                           input logic fs, input logic fl);
    pixel_word_t px;
    px.blue        = blue;
    px.red         = red;
    px.frame_start = fs;
    px.flush       = fl;
    pixel_q.push_back(px);
    words_queued++;
  endtask

  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  // register write, taken once valid and ready meet
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_COLOR_MODE:   mode_q   = data[COLOR_MODE_W-1:0];
      REG_THRESHOLD:    thresh_q = data[THRESHOLD_W-1:0];
      REG_FRAME_WIDTH:  width_q  = data[FRAME_WIDTH_W-1:0];
      REG_FRAME_HEIGHT: height_q = data[FRAME_HEIGHT_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // everything taken, every result back, pipeline empty
  task automatic wait_idle();
    while (words_sent != words_queued || dil_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic pick_config();
    logic [CFG_DATA_W-1:0] d;
    if ($urandom_range(0, 1)) begin
      d = CFG_DATA_W'($urandom);
      if ($urandom_range(0, 3) != 0) d[CFG_DATA_W-1:COLOR_MODE_W] = '0;
      write_reg(REG_COLOR_MODE, d);
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 5))
        0:       d = '0;
        1:       d = CFG_DATA_W'(255);
        default: d = CFG_DATA_W'($urandom_range(0, 160));
      endcase
      write_reg(REG_THRESHOLD, d);
    end
    if ($urandom_range(0, 1)) begin
      d = ($urandom_range(0, 7) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 12));
      d[CFG_DATA_W-1] = ($urandom_range(0, 3) == 0);
      write_reg(REG_FRAME_WIDTH, d);
    end
    if ($urandom_range(0, 1)) begin
      d = ($urandom_range(0, 7) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 6));
      write_reg(REG_FRAME_HEIGHT, d);
    end
  endtask

  // one frame in raster order, then a row of flush words; a broken one may be cut short and gets stray words instead
  task automatic send_frame(input bit broken, output int unsigned n_sent);
    int unsigned w, h, n_pix, cut;
    w     = eff_width();
    h     = eff_height();
    n_pix = w * h;
    cut   = broken ? $urandom_range(1, n_pix) : n_pix;
    for (int unsigned i = 0; i < cut; i++) push_word(rand_chan(), rand_chan(), i == 0, 1'b0);
    n_sent = cut;
    if (broken) begin
      repeat ($urandom_range(0, 3))
        push_word(rand_chan(), rand_chan(), $urandom_range(0, 3) == 0,
                  1'($urandom_range(0, 1)));
    end else begin
      repeat (w) push_word(rand_chan(), rand_chan(), $urandom_range(0, 3) == 0, 1'b1);
      n_sent += w;
      if ($urandom_range(0, 4) == 0)
        push_word(rand_chan(), rand_chan(), 1'b0, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : run_stimulus
    int unsigned rand_words;
    int unsigned n_sent;
    int          phase;
    int          guard;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);

    // red target, threshold zero, 3x3 frame
    write_reg(REG_COLOR_MODE, CFG_DATA_W'(MODE_RED));
    write_reg(REG_THRESHOLD, CFG_DATA_W'(0));
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
    push_word(8'd0, 8'd255, 1'b1, 1'b0);
    push_word(8'd0, 8'd0, 1'b0, 1'b1);      // flush before the rows are in
    push_word(8'd255, 8'd0, 1'b0, 1'b0);
    push_word(8'd128, 8'd128, 1'b0, 1'b0);  // equal channels stay clear
    push_word(8'd0, 8'd1, 1'b0, 1'b0);
    push_word(8'd0, 8'd0, 1'b0, 1'b0);
    push_word(8'd255, 8'd255, 1'b0, 1'b0);
    push_word(8'd0, 8'd0, 1'b0, 1'b0);
    push_word(8'd0, 8'd0, 1'b0, 1'b0);
    push_word(8'd10, 8'd200, 1'b0, 1'b0);
    push_word(8'd77, 8'd99, 1'b1, 1'b1);    // flush wins over frame start
    push_word(8'd0, 8'd0, 1'b0, 1'b1);
    push_word(8'd0, 8'd0, 1'b0, 1'b1);
    push_word(8'd0, 8'd0, 1'b0, 1'b1);      // drained already
    push_word(8'd0, 8'd255, 1'b0, 1'b0);    // frame complete
    wait_idle();

    // zero geometry acts as 1x1, blue target near the top threshold
    write_reg(REG_COLOR_MODE, CFG_DATA_W'(MODE_BLUE));
    write_reg(REG_THRESHOLD, CFG_DATA_W'(254));
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(0));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(0));
    push_word(8'd255, 8'd0, 1'b1, 1'b0);
    push_word(8'd255, 8'd0, 1'b0, 1'b0);
    push_word(8'd0, 8'd0, 1'b0, 1'b1);
    wait_idle();

    // undefined mode code behaves as off; frame start mid-frame drops pending rows
    write_reg(REG_COLOR_MODE, CFG_DATA_W'(MODE_OFF | MODE_BLUE));
    write_reg(REG_THRESHOLD, CFG_DATA_W'(255));
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(2));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
    push_word(8'd0, 8'd255, 1'b1, 1'b0);
    push_word(8'd255, 8'd0, 1'b0, 1'b0);
    push_word(8'd0, 8'd255, 1'b0, 1'b0);
    push_word(8'd0, 8'd255, 1'b1, 1'b0);
    repeat (3) push_word(rand_chan(), rand_chan(), 1'b0, 1'b0);
    repeat (2) push_word(8'd0, 8'd0, 1'b0, 1'b1);
    wait_idle();

    // widest row: width above the buffer depth clamps, second row cut short
    write_reg(REG_COLOR_MODE, CFG_DATA_W'(MODE_RED));
    write_reg(REG_THRESHOLD, CFG_DATA_W'(100));
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(2047));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
    for (int i = 0; i < MAX_W + 16; i++) push_word(rand_chan(), rand_chan(), i == 0, 1'b0);
    wait_idle();

    // tallest frame, one column, cut short
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(1));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(4095));
    for (int i = 0; i < 30; i++) push_word(rand_chan(), rand_chan(), i == 0, 1'b0);
    wait_idle();

    // random frames, settings changed between phases
    rand_words = 0;
    phase = 0;
    while (rand_words < 600 || phase < 10) begin
      calm      <= (phase >= 3 && phase <= 7);
      stall_req <= (phase == 9);
      if (phase == 0) begin
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(5));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(4));
      end
      if (phase == 9) begin
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(10));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(10));
      end else begin
        pick_config();
      end
      // resume the old position under new geometry
      if (phase != 0 && $urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 6)) push_word(rand_chan(), rand_chan(), 1'b0, 1'b0);
      repeat ((phase == 9) ? 1 : $urandom_range(1, 3)) begin
        send_frame((phase != 9) && ($urandom_range(0, 4) == 0), n_sent);
        rand_words += n_sent;
      end
      wait_idle();
      phase++;
    end
    calm      <= 1'b0;
    stall_req <= 1'b0;

    while (words_sent != words_queued) @(posedge clk_i);
    guard = 0;
    while (dil_expect_q.size() != 0 && guard < 50000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (dil_expect_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", dil_expect_q.size()));
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
